// ===== rtl/core/sorted_timer_queue_unit_assert.svh =====
// assertion macros for the rtl file sorted_timer_queue_unit.sv
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define STQU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define STQU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stqu_pkg.sv =====
package stqu_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [39:0] IDLE_RESET = 40'(1 * 1000 * 1000);

  // function codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_SLEEP  = 2'd3;

  typedef struct packed {
    logic [62:0] expiry;
    logic [39:0] period;
    logic        rep;
    logic [7:0]  handle;
  } ent_t;

  typedef struct packed {
    logic [39:0] period;
    logic [7:0]  handle;
  } arm_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WALK,
    S_INS_PUT,
    S_INS_ACK,
    S_TCK_RD,
    S_TCK_CHK,
    S_ARM_RD,
    S_ARM_LD,
    S_RPT_RD,
    S_RPT
  } state_e;

  // logical slot to physical slot of the circular table
  function automatic logic [IW-1:0] phys_idx(input logic [IW-1:0] hd,
                                             input logic [IW-1:0] lg);
    logic [IW:0] sum;
    sum = {1'b0, hd} + {1'b0, lg};
    if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

endpackage

// ===== rtl/core/stqu_if.sv =====
interface stqu_in_if;
  import stqu_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [61:0] now;
  logic [39:0] timeout;
  logic        periodic;
  logic [7:0]  handle;

  modport source (output valid, func, now, timeout, periodic, handle, input ready);
  modport sink (input valid, func, now, timeout, periodic, handle, output ready);
endinterface

interface stqu_out_if;
  import stqu_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  fired_handle;
  logic [62:0] sleep_us;
  logic        last;

  modport source (output valid, kind, fired_handle, sleep_us, last, input ready);
  modport sink (input valid, kind, fired_handle, sleep_us, last, output ready);
endinterface

// ===== rtl/core/sorted_timer_queue_unit.sv =====
// sorted timer queue
// in_i carries commands: insert (now, timeout, periodic, handle), tick and
// query; out_o carries results, each with a last flag on the final one of a
// command. insert answers with one accept or reject (table full), a tick
// gives one fired result per expired head timer in expiry order and then a
// sleep report, a query gives the sleep report alone.
// the table is a circular buffer in one synchronous ram with a head pointer;
// a second small ram keeps the periodic timers fired by a tick until they
// are put back. commands are handled one at a time: in_i is ready only when
// the sequencer is idle, even while a result still waits in the output
// register. an insert walks from the tail toward its slot, one entry moved
// per cycle through the read-compare-write loop on the table ram; a
// rejected insert goes straight to its result. a tick puts each fired
// periodic timer back with an insert walk of its own, after its fired
// results and before its sleep report.
// when out_o stalls the sequencer waits in the state that emits, state held.
// reset empties the table (count 0) and sets idle_sleep to 1000000; no ram
// clearing pass is needed. idle_sleep is written on the apb port at 0x0.
module sorted_timer_queue_unit
  import stqu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  stqu_in_if.sink     in_i,
  stqu_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o
);

  // sequencer state
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   hd_q, hd_d;
  logic [IW-1:0]   pos_q, pos_d;
  ent_t            new_q, new_d;
  logic [61:0]     now_q, now_d;
  logic [1:0]      knd_q, knd_d;
  logic [CW-1:0]   nrep_q, nrep_d;
  logic [IW-1:0]   ridx_q, ridx_d;
  logic            arm_q, arm_d;
  logic [39:0]     idle_q;

  // output register
  logic            ov_q, ov_d;
  logic [1:0]      okind_q, okind_d;
  logic [7:0]      ohnd_q, ohnd_d;
  logic [62:0]     osleep_q, osleep_d;
  logic            olast_q, olast_d;

  // table ram
  ent_t            ent_mem [QUEUE_DEPTH];
  ent_t            ent_rd_q;
  logic            ent_re, ent_we;
  logic [IW-1:0]   ent_raddr, ent_waddr;
  ent_t            ent_wdata;

  // re-arm ram
  arm_t            arm_mem [QUEUE_DEPTH];
  arm_t            arm_rd_q;
  logic            arm_re, arm_we;
  logic [IW-1:0]   arm_raddr;
  arm_t            arm_wdata;

  // shared decode
  logic            in_xfer, out_free, cfg_wr;
  logic            due, shift, rep_ok, last_fire, arm_last;
  logic [62:0]     head_gap;
  logic [CW-1:0]   nrep_inc;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  assign due       = ent_rd_q.expiry <= {1'b0, now_q};
  assign head_gap  = ent_rd_q.expiry - {1'b0, now_q};
  assign shift     = ent_rd_q.expiry > new_q.expiry;
  assign rep_ok    = ent_rd_q.rep;
  assign nrep_inc  = nrep_q + CW'(rep_ok);
  assign last_fire = (cnt_q == CW'(1));
  assign arm_last  = ({1'b0, ridx_q} + (IW+1)'(1)) == (IW+1)'(nrep_q);

  // apb register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && !paddr_i[3];
  assign prdata_o = paddr_i[3] ? 64'd0 : {24'd0, idle_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_i.func)
            FUNC_INSERT: state_d = (cnt_q == CW'(QUEUE_DEPTH)) ? S_INS_ACK : S_INS_RD;
            FUNC_TICK:   state_d = S_TCK_RD;
            FUNC_QUERY:  state_d = S_RPT_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: state_d = (cnt_q == '0) ? S_INS_PUT : S_INS_WALK;
      S_INS_WALK: begin
        if (shift) begin
          state_d = (pos_q == IW'(1)) ? S_INS_PUT : S_INS_WALK;
        end else if (arm_q) begin
          state_d = arm_last ? S_RPT_RD : S_ARM_RD;
        end else begin
          state_d = S_INS_ACK;
        end
      end
      S_INS_PUT: begin
        if (arm_q) begin
          state_d = arm_last ? S_RPT_RD : S_ARM_RD;
        end else begin
          state_d = S_INS_ACK;
        end
      end
      S_INS_ACK: if (out_free) state_d = S_IDLE;
      S_TCK_RD:  state_d = (cnt_q == '0) ? S_RPT_RD : S_TCK_CHK;
      S_TCK_CHK: begin
        if (!due) begin
          state_d = (nrep_q == '0) ? S_RPT_RD : S_ARM_RD;
        end else if (out_free && last_fire) begin
          state_d = (nrep_inc == '0) ? S_RPT_RD : S_ARM_RD;
        end
      end
      S_ARM_RD: state_d = S_ARM_LD;
      S_ARM_LD: state_d = S_INS_RD;
      S_RPT_RD: state_d = S_RPT;
      S_RPT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    cnt_d     = cnt_q;
    hd_d      = hd_q;
    pos_d     = pos_q;
    new_d     = new_q;
    now_d     = now_q;
    knd_d     = knd_q;
    nrep_d    = nrep_q;
    ridx_d    = ridx_q;
    arm_d     = arm_q;
    ov_d      = ov_q && !out_o.ready;
    okind_d   = okind_q;
    ohnd_d    = ohnd_q;
    osleep_d  = osleep_q;
    olast_d   = olast_q;
    ent_re    = 1'b0;
    ent_raddr = hd_q;
    ent_we    = 1'b0;
    ent_waddr = phys_idx(hd_q, pos_q);
    ent_wdata = new_q;
    arm_re    = 1'b0;
    arm_raddr = ridx_q;
    arm_we    = 1'b0;
    arm_wdata = '{period: ent_rd_q.period, handle: ent_rd_q.handle};
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          now_d        = in_i.now;
          new_d.expiry = {1'b0, in_i.now} + {23'd0, in_i.timeout};
          new_d.period = in_i.timeout;
          new_d.rep    = in_i.periodic;
          new_d.handle = in_i.handle;
          knd_d        = (cnt_q == CW'(QUEUE_DEPTH)) ? KIND_REJECT : KIND_ACCEPT;
          arm_d        = 1'b0;
        end
      end
      S_INS_RD: begin
        // start at the tail: the slot after the last entry
        pos_d     = cnt_q[IW-1:0];
        ent_re    = (cnt_q != '0);
        ent_raddr = phys_idx(hd_q, cnt_q[IW-1:0] - IW'(1));
      end
      S_INS_WALK: begin
        ent_we = 1'b1;
        if (shift) begin
          // later entry moves up one slot, keep walking toward the head
          ent_wdata = ent_rd_q;
          pos_d     = pos_q - IW'(1);
          ent_re    = (pos_q != IW'(1));
          ent_raddr = phys_idx(hd_q, pos_q - IW'(2));
        end else begin
          cnt_d  = cnt_q + CW'(1);
          ridx_d = ridx_q + IW'(1);
        end
      end
      S_INS_PUT: begin
        ent_we = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        ridx_d = ridx_q + IW'(1);
      end
      S_INS_ACK: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = knd_q;
          ohnd_d   = new_q.handle;
          osleep_d = '0;
          olast_d  = 1'b1;
        end
      end
      S_TCK_RD: begin
        nrep_d = '0;
        ridx_d = '0;
        ent_re = (cnt_q != '0);
      end
      S_TCK_CHK: begin
        if (due && out_free) begin
          ov_d     = 1'b1;
          okind_d  = KIND_FIRED;
          ohnd_d   = ent_rd_q.handle;
          osleep_d = '0;
          olast_d  = 1'b0;
          arm_we   = rep_ok;
          nrep_d   = nrep_inc;
          // drop the head, fetch the next one
          hd_d      = phys_idx(hd_q, IW'(1));
          cnt_d     = cnt_q - CW'(1);
          ent_re    = !last_fire;
          ent_raddr = phys_idx(hd_q, IW'(1));
        end
      end
      S_ARM_RD: arm_re = 1'b1;
      S_ARM_LD: begin
        new_d.expiry = {1'b0, now_q} + {23'd0, arm_rd_q.period};
        new_d.period = arm_rd_q.period;
        new_d.rep    = 1'b1;
        new_d.handle = arm_rd_q.handle;
        arm_d        = 1'b1;
      end
      S_RPT_RD: ent_re = (cnt_q != '0);
      S_RPT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_SLEEP;
          ohnd_d  = '0;
          olast_d = 1'b1;
          if (cnt_q == '0) begin
            osleep_d = {23'd0, idle_q};
          end else if (due) begin
            osleep_d = '0;
          end else begin
            osleep_d = head_gap;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      hd_q    <= '0;
      nrep_q  <= '0;
      ridx_q  <= '0;
      arm_q   <= 1'b0;
      ov_q    <= 1'b0;
      idle_q  <= IDLE_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hd_q    <= hd_d;
      nrep_q  <= nrep_d;
      ridx_q  <= ridx_d;
      arm_q   <= arm_d;
      ov_q    <= ov_d;
      if (cfg_wr) begin
        idle_q <= pwdata_i[39:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    new_q    <= new_d;
    now_q    <= now_d;
    knd_q    <= knd_d;
    okind_q  <= okind_d;
    ohnd_q   <= ohnd_d;
    osleep_q <= osleep_d;
    olast_q  <= olast_d;
  end

  // table ram, read data registered and held when not read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  // re-arm ram
  always_ff @(posedge clk_i) begin
    if (arm_we) begin
      arm_mem[nrep_q[IW-1:0]] <= arm_wdata;
    end
    if (arm_re) begin
      arm_rd_q <= arm_mem[arm_raddr];
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.kind         = okind_q;
  assign out_o.fired_handle = ohnd_q;
  assign out_o.sleep_us     = osleep_q;
  assign out_o.last         = olast_q;

`include "sorted_timer_queue_unit_assert.svh"

  `STQU_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CW'(QUEUE_DEPTH), "entry count above depth")
  `STQU_ASSERT_IMPL(a_walk_room, state_q == S_INS_WALK || state_q == S_INS_PUT,
                    cnt_q < CW'(QUEUE_DEPTH), "insert walk on a full table")
  `STQU_ASSERT_IMPL(a_fired_not_last, ov_q && okind_q == KIND_FIRED, !olast_q,
                    "fired result flagged last")
  `STQU_ASSERT_NEXT(a_fire_pops, state_q == S_TCK_CHK && due && out_free,
                    cnt_q == $past(cnt_q) - CW'(1), "fired timer not removed")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import stqu_pkg::*;

  // command code that the block drops without any result
  localparam logic [1:0]  FUNC_UNUSED     = 2'd3;
  localparam logic [3:0]  ADDR_IDLE_SLEEP = 4'h0;
  localparam logic [61:0] NOW_MAX         = '1;
  localparam logic [39:0] TIMEOUT_MAX     = '1;
  // long receiver hold-off, well above the deepest tick of the block
  localparam int HOLD_CYCLES   = 300;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // quiet cycles after the last result, covers a dropped command in flight
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 86;

  typedef struct {
    logic [62:0] expiry;
    logic [39:0] period;
    logic        rep;
    logic [7:0]  handle;
  } timer_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  fired_handle;
    logic [62:0] sleep_us;
    logic        last;
  } result_t;

  // mirror of the timer table plus the queue of results still to come
  class timer_scoreboard;
    timer_t      timer_table_q[$];
    result_t     pending_results_q[$];
    logic [39:0] idle_sleep;
    int          errors;

    function new();
      idle_sleep = IDLE_RESET;
      errors     = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function void set_idle_sleep(logic [39:0] value);
      idle_sleep = value;
    endfunction

    function int pending();
      return pending_results_q.size();
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] h, logic [62:0] sl, logic last);
      result_t r;
      r.kind         = kind;
      r.fired_handle = h;
      r.sleep_us     = sl;
      r.last         = last;
      pending_results_q.push_back(r);
    endfunction

    // sorted placement, after every entry with an equal or earlier expiry
    function bit arm(timer_t t);
      int pos;
      if (timer_table_q.size() >= QUEUE_DEPTH) return 1'b0;
      pos = 0;
      while (pos < timer_table_q.size() && timer_table_q[pos].expiry <= t.expiry) pos++;
      timer_table_q.insert(pos, t);
      return 1'b1;
    endfunction

    function logic [62:0] sleep_for(logic [62:0] now);
      if (timer_table_q.size() == 0) return {23'b0, idle_sleep};
      if (timer_table_q[0].expiry <= now) return '0;
      return timer_table_q[0].expiry - now;
    endfunction

    function void note_command(logic [1:0] func, logic [61:0] now, logic [39:0] timeout,
                               logic periodic, logic [7:0] handle);
      timer_t      t;
      timer_t      rearm_q[$];
      logic [62:0] now_x;
      now_x    = {1'b0, now};
      t.expiry = now_x + {23'b0, timeout};
      t.period = timeout;
      t.rep    = periodic;
      t.handle = handle;
      case (func)
        FUNC_INSERT: begin
          add_result(arm(t) ? KIND_ACCEPT : KIND_REJECT, handle, '0, 1'b1);
        end
        FUNC_TICK: begin
          while (timer_table_q.size() != 0 && timer_table_q[0].expiry <= now_x) begin
            t = timer_table_q.pop_front();
            add_result(KIND_FIRED, t.handle, '0, 1'b0);
            if (t.rep) rearm_q.push_back(t);
          end
          foreach (rearm_q[i]) begin
            t        = rearm_q[i];
            t.expiry = now_x + {23'b0, t.period};
            void'(arm(t));
          end
          add_result(KIND_SLEEP, '0, sleep_for(now_x), 1'b1);
        end
        FUNC_QUERY: begin
          add_result(KIND_SLEEP, '0, sleep_for(now_x), 1'b1);
        end
        default: ;
      endcase
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending_results_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d handle %0h", got.kind, got.fired_handle));
      end else begin
        want = pending_results_q.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.fired_handle !== want.fired_handle)
          report($sformatf("handle %0h, expected %0h", got.fired_handle, want.fired_handle));
        if (got.sleep_us !== want.sleep_us)
          report($sformatf("sleep %0d, expected %0d", got.sleep_us, want.sleep_us));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        apb_psel;
  logic        apb_penable;
  logic        apb_pwrite;
  logic [3:0]  apb_paddr;
  logic [63:0] apb_pwdata;
  logic [63:0] apb_prdata;
  logic        apb_pready;

  stqu_in_if  in_if ();
  stqu_out_if out_if ();

  sorted_timer_queue_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .psel_i    (apb_psel),
    .penable_i (apb_penable),
    .pwrite_i  (apb_pwrite),
    .paddr_i   (apb_paddr),
    .pwdata_i  (apb_pwdata),
    .prdata_o  (apb_prdata),
    .pready_o  (apb_pready)
  );

  timer_scoreboard sb;

  // idling knobs, percent of cycles, changed per phase
  int send_idle_pct;
  int stall_pct;
  // hold-off request: main bumps hold_ask, the receiver counts the stretch
  int hold_ask;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  // running system time for the well-formed part of the stimulus
  logic [61:0] cur_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_seen    <= hold_ask;
      hold_left    <= 0;
      out_if.ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen    <= hold_ask;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: check results, note accepted commands, watch for a hang
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if (out_if.valid && out_if.ready)
        sb.check_result('{out_if.kind, out_if.fired_handle, out_if.sleep_us, out_if.last});
      // a command is noted after any result of the same edge, which belongs to an older one
      if (in_if.valid && in_if.ready)
        sb.note_command(in_if.func, in_if.now, in_if.timeout, in_if.periodic, in_if.handle);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one command transfer, with random idle cycles in front of it
  task automatic send_cmd(input logic [1:0] func, input logic [61:0] now,
                          input logic [39:0] timeout, input logic periodic,
                          input logic [7:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= func;
    in_if.now      <= now;
    in_if.timeout  <= timeout;
    in_if.periodic <= periodic;
    in_if.handle   <= handle;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // sender pauses until every expected result has been seen; the first edge
  // lets the monitor note the command of the last transfer
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // register write (setup then access), then read back
  task automatic config_idle_sleep(input logic [39:0] value);
    apb_psel    <= 1'b1;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b1;
    apb_paddr   <= ADDR_IDLE_SLEEP;
    apb_pwdata  <= {24'b0, value};
    @(posedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    sb.set_idle_sleep(value);
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b0;
    @(posedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    if (apb_prdata[39:0] !== value)
      sb.report($sformatf("idle_sleep reads %0d, written %0d", apb_prdata[39:0], value));
    apb_psel    <= 1'b0;
    apb_penable <= 1'b0;
  endtask

  // random traffic: mostly timed inserts and ticks on a rising clock,
  // bursts that pile up equal expiries, queries at any time, some noise
  task automatic run_phase(input int n_items, input bit long_hold, input bit full_pause);
    int          done_items;
    int          pick;
    int          burst;
    bit          held;
    bit          paused;
    logic [39:0] tmo;
    logic [61:0] jump_to;
    done_items = 0;
    held       = 1'b0;
    paused     = 1'b0;
    while (done_items < n_items) begin
      if (long_hold && !held && done_items >= 20) begin
        // hold the result side while commands keep coming
        hold_ask <= hold_ask + 1;
        held = 1'b1;
      end
      if (full_pause && !paused && done_items >= n_items / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        // burst of short timers, many sharing an expiry, then a tick past them
        burst = $urandom_range(4, 16);
        repeat (burst)
          send_cmd(FUNC_INSERT, cur_now, 40'($urandom_range(3) * 10), 1'b0, 8'($urandom));
        cur_now = cur_now + 40;
        send_cmd(FUNC_TICK, cur_now, 40'($urandom), 1'($urandom), 8'($urandom));
        done_items += burst + 1;
      end else if (pick < 45) begin
        case ($urandom_range(9))
          0:       tmo = '0;
          1:       tmo = 40'(rand64());
          default: tmo = 40'($urandom_range(1, 300));
        endcase
        send_cmd(FUNC_INSERT, cur_now, tmo, ($urandom_range(31) == 0), 8'($urandom));
        done_items++;
      end else if (pick < 75) begin
        cur_now = cur_now + $urandom_range(0, 120);
        send_cmd(FUNC_TICK, cur_now, 40'(rand64()), 1'($urandom), 8'($urandom));
        done_items++;
      end else if (pick < 92) begin
        if ($urandom_range(3) == 0)
          send_cmd(FUNC_QUERY, 62'(rand64()), 40'(rand64()), 1'($urandom), 8'($urandom));
        else
          send_cmd(FUNC_QUERY, cur_now + $urandom_range(0, 100), 40'(rand64()),
                   1'($urandom), 8'($urandom));
        done_items++;
      end else if (pick < 95) begin
        // forward jump of the time base, flushes far-off timers
        jump_to = {1'b0, 61'(rand64())};
        if (jump_to > cur_now) cur_now = jump_to;
      end else begin
        send_cmd(FUNC_UNUSED, 62'(rand64()), 40'(rand64()), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_QUERY;
    in_if.now      = '0;
    in_if.timeout  = '0;
    in_if.periodic = 1'b0;
    in_if.handle   = '0;
    apb_psel       = 1'b0;
    apb_penable    = 1'b0;
    apb_pwrite     = 1'b0;
    apb_paddr      = ADDR_IDLE_SLEEP;
    apb_pwdata     = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_ask       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table at the reset idle value
    send_cmd(FUNC_QUERY, '0, '0, 1'b0, 8'h00);
    // field extremes, both expire on a tick at the latest time
    send_cmd(FUNC_INSERT, '0, TIMEOUT_MAX, 1'b0, 8'h00);
    send_cmd(FUNC_INSERT, NOW_MAX, '0, 1'b0, 8'hFF);
    send_cmd(FUNC_TICK, NOW_MAX, '0, 1'b0, 8'h00);
    // fill the table with one shared expiry, two of them periodic
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_cmd(FUNC_INSERT, 62'd100, 40'd50, (i == 3 || i == 12), 8'(i * 17));
    // full table rejects
    send_cmd(FUNC_INSERT, 62'd120, 40'd30, 1'b1, 8'hA5);
    // fire all sixteen in table order, periodic ones come back
    send_cmd(FUNC_TICK, 62'd150, '0, 1'b0, 8'h00);
    // zero period: re-armed at now, fires again only on the next tick
    send_cmd(FUNC_INSERT, 62'd160, '0, 1'b1, 8'h5A);
    send_cmd(FUNC_TICK, 62'd160, '0, 1'b0, 8'h00);
    send_cmd(FUNC_TICK, 62'd170, '0, 1'b0, 8'h00);
    // unused code is dropped
    send_cmd(FUNC_UNUSED, 62'(rand64()), 40'(rand64()), 1'b1, 8'($urandom));
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cur_now = 62'd200;

    // phase 1: no idling, idle value at its low extreme
    config_idle_sleep('0);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // phase 2: sender idles, one full drain pause, idle value at its top
    send_idle_pct = 54;
    stall_pct     = 0;
    config_idle_sleep(TIMEOUT_MAX);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // phase 3: receiver stalls, plus the long hold-off
    send_idle_pct = 0;
    stall_pct     = 54;
    config_idle_sleep(40'(rand64()));
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // phase 4: light idling on both sides
    send_idle_pct = 12;
    stall_pct     = 12;
    config_idle_sleep(40'($urandom));
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
